// ----- hdl/pavm_pkg.sv -----
// shared types, register codes and arithmetic constants of the voice mixer
`timescale 1ns / 1ps
package pavm_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd4;

    // register reset values
    localparam logic [31:0] ATTACK_RST  = 32'd6554;
    localparam logic [31:0] DECAY_RST   = 32'd655;
    localparam logic [31:0] RELEASE_RST = 32'd13107;
    localparam logic [15:0] PEAK_RST    = 16'd32768;
    localparam logic [15:0] SUSTAIN_RST = 16'd26214;

    // shared divider widths
    localparam int DIV_DW = 48;
    localparam int DIV_VW = 32;

    // fixed point constants
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam logic [31:0] TWO_OVER_PI_Q30 = 32'd683565276;
    localparam logic signed [16:0] HALF_PI_Q14 = 17'sd25736;
    localparam logic [15:0] LEVEL_FLOOR = 16'd3;

    // output scaling by 1/327680: drop 16 bits, then multiply by the q26 reciprocal of 5
    localparam int SCALE_SHIFT = 26;
    localparam logic [23:0] SCALE_RECIP = 24'd13421773;

    // semitone pitches of the A440 octave, Q16.16 Hz
    localparam logic [31:0] SEMITONE_HZ [12] = '{
        32'd28835840, 32'd30550508, 32'd32367136, 32'd34291786,
        32'd36330882, 32'd38491228, 32'd40780036, 32'd43204943,
        32'd45774043, 32'd48495909, 32'd51379626, 32'd54434817
    };

    // one voice record
    typedef struct packed {
        logic        present;
        logic        active;
        logic [31:0] on_stamp;
        logic [31:0] off_stamp;
        logic [15:0] level;
    } voice_t;

    // pitch of a key, Q16.16 Hz
    function automatic logic [31:0] key_freq(input int k);
        int idx;
        int oct;
        logic [31:0] f;
        idx = k + 10;
        oct = idx / 12;
        f = SEMITONE_HZ[idx % 12];
        if (oct >= 2) begin
            return f << (oct - 2);
        end
        return f >> (2 - oct);
    endfunction

endpackage

// ----- hdl/pavm_voice_cell.sv -----
// one voice cell of the rotating voice ring
`timescale 1ns / 1ps
module pavm_voice_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic             wr_en,
    input  pavm_pkg::voice_t nb_voice,
    input  pavm_pkg::voice_t wr_voice,
    output pavm_pkg::voice_t voice
);
    import pavm_pkg::*;

    voice_t voice_reg;

    // take the neighbor's voice on a shift, else an update from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_reg <= '0;
        end else if (shift_en) begin
            voice_reg <= nb_voice;
        end else if (wr_en) begin
            voice_reg <= wr_voice;
        end
    end

    assign voice = voice_reg;

endmodule

// ----- hdl/pavm_divider.sv -----
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pavm_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        go,
    input  logic [pavm_pkg::DIV_DW-1:0] dividend,
    input  logic [pavm_pkg::DIV_VW-1:0] divisor,
    output logic                        done,
    output logic [pavm_pkg::DIV_DW-1:0] quotient
);
    import pavm_pkg::*;

    localparam int CW = $clog2(DIV_DW);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] rem_next;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_VW-1:0] dv_reg;
    logic [DIV_VW:0]   r_sh;
    logic              q_bit;

    // trial subtract of the shifted remainder
    always_comb begin
        r_sh = {rem_reg, quo_reg[DIV_DW-1]};
        q_bit = (r_sh >= {1'b0, dv_reg});
        rem_next = q_bit ? DIV_VW'(r_sh - {1'b0, dv_reg}) : r_sh[DIV_VW-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (go) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_DW-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

    a_go_idle: assert property (@(posedge aclk) disable iff (!aresetn) go |-> !busy_reg)
        else $error("divider started while busy");
    a_go_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        go |-> divisor != '0)
        else $error("divider started with zero divisor");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

// ----- hdl/polyphonic_adsr_voice_mixer.sv -----
// polyphonic adsr voice mixer: ring of voice cells, one shared envelope/oscillator unit
// key request: up to NUM_KEYS-1 ring shifts to bring the voice to the head, then the key update;
//   a released voice that is re-armed also runs the shared divider
// tick request: per active voice the envelope level (through the divider in attack, decay and
//   release), then 5 oscillator steps; idle voices are skipped; final scaling and output; one request at a time
// reset: synchronous active low, clears all voices and loads register defaults at once
`timescale 1ns / 1ps
module polyphonic_adsr_voice_mixer #(
    parameter int NUM_KEYS = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pavm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [3:0]                       s_key_index,
    input  logic                             s_key_pressed,
    input  logic [31:0]                      s_time_stamp,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [19:0]               m_sample_value
);
    import pavm_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNT_W = $clog2(NUM_KEYS + 1);
    localparam int SIW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int ACC_W = 35 + $clog2(NUM_KEYS);
    localparam int MAG_W = ACC_W - 16;

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SEEK  = 5'd1;
    localparam logic [4:0] ST_KEY   = 5'd2;
    localparam logic [4:0] ST_RFIN  = 5'd3;
    localparam logic [4:0] ST_VSEL  = 5'd4;
    localparam logic [4:0] ST_LDT   = 5'd5;
    localparam logic [4:0] ST_LSEL  = 5'd6;
    localparam logic [4:0] ST_LMUL  = 5'd7;
    localparam logic [4:0] ST_LWAIT = 5'd8;
    localparam logic [4:0] ST_LFIN  = 5'd9;
    localparam logic [4:0] ST_PH    = 5'd10;
    localparam logic [4:0] ST_SAW   = 5'd11;
    localparam logic [4:0] ST_SIN   = 5'd12;
    localparam logic [4:0] ST_MUL   = 5'd13;
    localparam logic [4:0] ST_ACC   = 5'd14;
    localparam logic [4:0] ST_NEXT  = 5'd15;
    localparam logic [4:0] ST_FDIV  = 5'd16;
    localparam logic [4:0] ST_FWAIT = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    // envelope segment codes
    localparam logic [2:0] LC_ZERO = 3'd0;
    localparam logic [2:0] LC_ATT  = 3'd1;
    localparam logic [2:0] LC_DEC  = 3'd2;
    localparam logic [2:0] LC_SUS  = 3'd3;
    localparam logic [2:0] LC_REL  = 3'd4;

    function automatic longint sine_entry(input int i);
        longint t;
        longint r;
        longint x;
        longint x2;
        longint p;
        int q;
        t = (longint'(i) <<< 32) / SINE_TABLE_DEPTH;
        q = int'((t >>> 30) & 64'sd3);
        r = t & 64'sh3FFF_FFFF;
        if (q[0]) begin
            r = ONE_Q30 - r;
        end
        x = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        p = ONE_Q30 - x2 / 110;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 72;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 42;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 20;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 6;
        p = (x * p) >>> 30;
        p = (p + 64'sd32768) >>> 16;
        return (q >= 2) ? -p : p;
    endfunction

    logic [31:0] attack_reg;
    logic [31:0] decay_reg;
    logic [31:0] release_reg;
    logic [15:0] peak_reg;
    logic [15:0] sustain_reg;

    logic [4:0]       state_reg;
    logic [4:0]       state_next;
    logic [KW-1:0]    head_key_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic signed [19:0] m_data_reg;
    logic             div_go_reg;

    logic             op_reg;
    logic [3:0]       key_reg;
    logic             pressed_reg;
    logic [31:0]      time_reg;
    logic             held_reg;
    logic [31:0]      dt_reg;
    logic [2:0]       lcase_reg;
    logic             dneg_reg;
    logic [31:0]      mul_a_reg;
    logic [15:0]      mul_b_reg;
    logic [DIV_DW-1:0] dividend_reg;
    logic [DIV_VW-1:0] divisor_reg;
    logic [31:0]      ph_reg;
    logic [61:0]      saw_prod_reg;
    logic [SIW-1:0]   sidx_reg;
    logic signed [15:0] sine_reg;
    logic signed [16:0] saw_reg;
    logic signed [34:0] vprod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic             acc_neg_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] scaled_reg;

    logic             div_done;
    logic [DIV_DW-1:0] quot;

    voice_t           cell_q [NUM_KEYS];
    voice_t           head;
    voice_t           head_wr_data;
    logic             head_wr;
    logic             shift;
    logic             key_hit;
    logic             s_acc;

    logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
    logic [31:0]        freq_tab [NUM_KEYS];

    logic [15:0]      q16;
    logic [16:0]      lvl_sum;
    logic [15:0]      lvl_raw;
    logic [15:0]      lvl_fin;
    logic [DIV_DW-1:0] back_cmp;
    logic signed [17:0] osc;
    logic signed [19:0] out_val;
    logic [ACC_W-1:0] acc_abs;
    logic [MAG_W+23:0] scale_prod;

    // constant tables
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
        assign sine_rom[g] = 16'(sine_entry(g));
    end
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_freq
        assign freq_tab[g] = key_freq(g);
    end

    // ring of voice cells, head at cell 0
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
        pavm_voice_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift),
            .wr_en    ((g == 0) ? head_wr : 1'b0),
            .nb_voice (cell_q[(g + 1) % NUM_KEYS]),
            .wr_voice (head_wr_data),
            .voice    (cell_q[g])
        );
    end
    assign head = cell_q[0];

    pavm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc = s_valid && s_ready;
    assign key_hit = (32'(head_key_reg) == 32'(key_reg));
    assign shift = ((state_reg == ST_SEEK) && !key_hit) || (state_reg == ST_NEXT);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= ATTACK_RST;
            decay_reg   <= DECAY_RST;
            release_reg <= RELEASE_RST;
            peak_reg    <= PEAK_RST;
            sustain_reg <= SUSTAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_wdata;
                REG_DECAY:   decay_reg   <= cfg_wdata;
                REG_RELEASE: release_reg <= cfg_wdata;
                REG_PEAK:    peak_reg    <= cfg_wdata[15:0];
                REG_SUSTAIN: sustain_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // level finish: segment value, clamp and floor
    always_comb begin
        q16 = (|quot[DIV_DW-1:16]) ? 16'hFFFF : quot[15:0];
        lvl_sum = '0;
        case (lcase_reg)
            LC_ATT: lvl_raw = q16;
            LC_DEC: begin
                if (dneg_reg) begin
                    lvl_sum = {1'b0, peak_reg} - {1'b0, q16};
                    lvl_raw = lvl_sum[16] ? 16'd0 : lvl_sum[15:0];
                end else begin
                    lvl_sum = {1'b0, peak_reg} + {1'b0, q16};
                    lvl_raw = lvl_sum[16] ? 16'hFFFF : lvl_sum[15:0];
                end
            end
            LC_SUS: lvl_raw = sustain_reg;
            LC_REL: lvl_raw = q16;
            default: lvl_raw = 16'd0;
        endcase
        lvl_fin = (lvl_raw <= LEVEL_FLOOR) ? 16'd0 : lvl_raw;
        back_cmp = quot;
    end

    // head cell updates
    always_comb begin
        head_wr = 1'b0;
        head_wr_data = head;
        case (state_reg)
            ST_KEY: begin
                if (pressed_reg) begin
                    if (!head.present) begin
                        head_wr = 1'b1;
                        head_wr_data.present = 1'b1;
                        head_wr_data.active = 1'b1;
                        head_wr_data.on_stamp = time_reg;
                        head_wr_data.off_stamp = '0;
                        head_wr_data.level = '0;
                    end
                end else if (head.present && (head.off_stamp < head.on_stamp)) begin
                    head_wr = 1'b1;
                    head_wr_data.off_stamp = time_reg;
                end
            end
            ST_RFIN: begin
                head_wr = 1'b1;
                head_wr_data.active = 1'b1;
                head_wr_data.on_stamp = (back_cmp >= DIV_DW'(time_reg)) ? 32'd0
                                      : time_reg - back_cmp[31:0];
            end
            ST_LFIN: begin
                head_wr = 1'b1;
                head_wr_data.level = lvl_fin;
                if ((lvl_fin == 16'd0) && (head.off_stamp > head.on_stamp)) begin
                    head_wr_data.active = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!s_op) begin
                        state_next = ST_VSEL;
                    end else if (32'(s_key_index) < NUM_KEYS) begin
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK: if (key_hit) state_next = ST_KEY;
            ST_KEY: begin
                if (pressed_reg && head.present && (head.off_stamp >= head.on_stamp)) begin
                    state_next = ST_LMUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RFIN: state_next = ST_IDLE;
            ST_VSEL: begin
                if (cnt_reg == CNT_W'(NUM_KEYS)) begin
                    state_next = ST_FDIV;
                end else if (head.present && head.active) begin
                    state_next = ST_LDT;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_LDT: state_next = ST_LSEL;
            ST_LSEL: begin
                if (held_reg) begin
                    if (dt_reg <= attack_reg) begin
                        state_next = ST_LMUL;
                    end else if ({1'b0, dt_reg} <= ({1'b0, attack_reg} + {1'b0, decay_reg})) begin
                        state_next = ST_LMUL;
                    end else begin
                        state_next = ST_LFIN;
                    end
                end else if (dt_reg >= release_reg) begin
                    state_next = ST_LFIN;
                end else begin
                    state_next = ST_LMUL;
                end
            end
            ST_LMUL: state_next = ST_LWAIT;
            ST_LWAIT: if (div_done) state_next = op_reg ? ST_RFIN : ST_LFIN;
            ST_LFIN: state_next = ST_PH;
            ST_PH: state_next = ST_SAW;
            ST_SAW: state_next = ST_SIN;
            ST_SIN: state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC: state_next = ST_NEXT;
            ST_NEXT: state_next = ST_VSEL;
            ST_FDIV: state_next = ST_FWAIT;
            ST_FWAIT: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_key_reg <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            div_go_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == ST_LMUL);
            if (shift) begin
                head_key_reg <= (head_key_reg == KW'(NUM_KEYS - 1)) ? '0
                              : head_key_reg + 1'b1;
            end
            if (s_acc) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_NEXT) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == ST_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // oscillator sum, output scaling and saturated output value
    always_comb begin
        osc = 18'(saw_reg) + 18'(sine_reg);
        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        scale_prod = (MAG_W+24)'(mag_reg) * (MAG_W+24)'(SCALE_RECIP);
        if (acc_neg_reg) begin
            out_val = (32'(scaled_reg) >= 32'd524288) ? 20'sh80000
                    : 20'sd0 - $signed(20'(scaled_reg));
        end else begin
            out_val = (32'(scaled_reg) > 32'd524287) ? 20'sh7FFFF : $signed(20'(scaled_reg));
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg      <= s_op;
            key_reg     <= s_key_index;
            pressed_reg <= s_key_pressed;
            time_reg    <= s_time_stamp;
            acc_reg     <= '0;
        end
        if (state_reg == ST_KEY) begin
            mul_a_reg   <= attack_reg;
            mul_b_reg   <= head.level;
            divisor_reg <= (peak_reg == 16'd0) ? 32'd1 : 32'(peak_reg);
        end
        if (state_reg == ST_LDT) begin
            held_reg <= head.on_stamp > head.off_stamp;
            if (head.on_stamp > head.off_stamp) begin
                dt_reg <= (time_reg > head.on_stamp) ? time_reg - head.on_stamp : 32'd0;
            end else begin
                dt_reg <= (time_reg > head.off_stamp) ? time_reg - head.off_stamp : 32'd0;
            end
        end
        if (state_reg == ST_LSEL) begin
            dneg_reg <= sustain_reg < peak_reg;
            if (held_reg) begin
                if (dt_reg <= attack_reg) begin
                    lcase_reg   <= LC_ATT;
                    mul_a_reg   <= dt_reg;
                    mul_b_reg   <= peak_reg;
                    divisor_reg <= (attack_reg == 32'd0) ? 32'd1 : attack_reg;
                end else if ({1'b0, dt_reg} <= ({1'b0, attack_reg} + {1'b0, decay_reg})) begin
                    lcase_reg   <= LC_DEC;
                    mul_a_reg   <= dt_reg - attack_reg;
                    mul_b_reg   <= (sustain_reg < peak_reg) ? peak_reg - sustain_reg
                                 : sustain_reg - peak_reg;
                    divisor_reg <= (decay_reg == 32'd0) ? 32'd1 : decay_reg;
                end else begin
                    lcase_reg <= LC_SUS;
                end
            end else if (dt_reg >= release_reg) begin
                lcase_reg <= LC_ZERO;
            end else begin
                lcase_reg   <= LC_REL;
                mul_a_reg   <= release_reg - dt_reg;
                mul_b_reg   <= sustain_reg;
                divisor_reg <= (release_reg == 32'd0) ? 32'd1 : release_reg;
            end
        end
        if (state_reg == ST_LMUL) begin
            dividend_reg <= DIV_DW'(mul_a_reg) * DIV_DW'(mul_b_reg);
        end
        if (state_reg == ST_PH) begin
            ph_reg <= 32'(freq_tab[head_key_reg] * time_reg);
        end
        if (state_reg == ST_SAW) begin
            saw_prod_reg <= 62'(64'(ph_reg) * 64'(TWO_OVER_PI_Q30));
            sidx_reg     <= SIW'((64'(ph_reg) * 64'(SINE_TABLE_DEPTH)) >> 32);
        end
        if (state_reg == ST_SIN) begin
            sine_reg <= sine_rom[sidx_reg];
            saw_reg  <= $signed({3'b000, saw_prod_reg[61:48]}) - HALF_PI_Q14;
        end
        if (state_reg == ST_MUL) begin
            vprod_reg <= 35'($signed({1'b0, head.level}) * osc);
        end
        if (state_reg == ST_ACC) begin
            acc_reg <= acc_reg + ACC_W'(vprod_reg);
        end
        // magnitude over 65536, then divide by 5 with the reciprocal
        if (state_reg == ST_FDIV) begin
            acc_neg_reg <= acc_reg[ACC_W-1];
            mag_reg     <= acc_abs[ACC_W-1:16];
        end
        if (state_reg == ST_FWAIT) begin
            scaled_reg <= MAG_W'(scale_prod >> SCALE_SHIFT);
        end
        if ((state_reg == ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_data_reg <= out_val;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sample_value = m_data_reg;

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(head_key_reg) < NUM_KEYS)
        else $error("head key out of range");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= NUM_KEYS)
        else $error("voice count overrun");
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_LWAIT))
        else $error("divider result with no waiting state");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

endmodule

// ----- tb/pavm_checker.sv -----
// request/result monitor with envelope and mixer prediction for the voice mixer
`timescale 1ns / 1ps
module pavm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pavm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_op,
    input  logic [3:0]                     s_key_index,
    input  logic                           s_key_pressed,
    input  logic [31:0]                    s_time_stamp,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [19:0]             m_sample_value,
    output int                             mismatches,
    output int                             samples_owed
);
    import pavm_pkg::*;

    localparam int KEYS = 16;
    localparam int SINE_DEPTH = 1024;

    // model copy of registers and voices
    logic [31:0] atk_t, dec_t, rel_t;
    logic [15:0] peak_lvl, sus_lvl;
    logic        v_present [KEYS];
    logic        v_active  [KEYS];
    logic [31:0] v_on      [KEYS];
    logic [31:0] v_off     [KEYS];
    logic [15:0] v_lvl     [KEYS];
    int          sine_lut  [SINE_DEPTH];
    logic signed [19:0] sample_q [$];

    // polynomial sine in q30, rounded to q14
    function automatic int sine_q14(input int unsigned i);
        longint unsigned t;
        int unsigned quad;
        longint r, x, x2, p;
        t = (longint'(i) << 32) / SINE_DEPTH;
        quad = (t >> 30) & 3;
        r = t & 64'h3FFF_FFFF;
        if (quad & 1) r = ONE_Q30 - r;
        x = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        p = ONE_Q30 - x2 / 110;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 72;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 42;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 20;
        p = ONE_Q30 - ((x2 * p) >>> 30) / 6;
        p = (x * p) >>> 30;
        p = (p + 32768) >>> 16;
        return (quad >= 2) ? int'(-p) : int'(p);
    endfunction

    // key pitch in q16.16 hz, a440 octave scaled by octave
    function automatic longint unsigned pitch_q16(input int k);
        int semi;
        int octave;
        longint unsigned base;
        semi = k + 10;
        octave = semi / 12;
        base = SEMITONE_HZ[semi % 12];
        if (octave >= 2) return base << (octave - 2);
        return base >> (2 - octave);
    endfunction

    function automatic longint unsigned at_least_one(input longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // envelope level of one voice at time now
    task automatic advance_envelope(input int k, input logic [31:0] now);
        longint unsigned dt, a, d, rl;
        longint lvl;
        if (v_on[k] > v_off[k]) begin
            dt = (now > v_on[k]) ? now - v_on[k] : 0;
            a = atk_t;
            d = dec_t;
            if (dt <= a) begin
                lvl = longint'(dt * peak_lvl / at_least_one(a));
            end else if (dt <= a + d) begin
                lvl = longint'(peak_lvl) + (longint'(dt - a) *
                      (longint'(sus_lvl) - longint'(peak_lvl))) / longint'(at_least_one(d));
            end else begin
                lvl = sus_lvl;
            end
        end else begin
            dt = (now > v_off[k]) ? now - v_off[k] : 0;
            rl = rel_t;
            lvl = (dt >= rl) ? 0 : longint'(longint'(sus_lvl) * (rl - dt) / at_least_one(rl));
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 65535) lvl = 65535;
        if (lvl <= LEVEL_FLOOR) lvl = 0;
        if (lvl == 0 && v_off[k] > v_on[k]) v_active[k] = 1'b0;
        v_lvl[k] = lvl[15:0];
    endtask

    // mixed sample of all active voices at time now
    task automatic mix_sample(input logic [31:0] now, output logic signed [19:0] smp);
        longint acc, saw, sn, s;
        logic [31:0] ph;
        acc = 0;
        for (int k = 0; k < KEYS; k++) begin
            if (!v_present[k] || !v_active[k]) continue;
            advance_envelope(k, now);
            ph = 32'(pitch_q16(k) * now);
            saw = longint'((longint'(ph) * longint'(TWO_OVER_PI_Q30)) >> 48) - HALF_PI_Q14;
            sn = sine_lut[ph >> 22];
            acc += longint'(v_lvl[k]) * (saw + sn);
        end
        s = acc / 327680;
        if (s > 524287) s = 524287;
        if (s < -524288) s = -524288;
        smp = s[19:0];
    endtask

    // key press or release
    task automatic apply_key(input int k, input logic down, input logic [31:0] now);
        longint unsigned back;
        if (down) begin
            if (!v_present[k]) begin
                v_present[k] = 1'b1;
                v_active[k] = 1'b1;
                v_on[k] = now;
                v_off[k] = 0;
                v_lvl[k] = 0;
            end else if (v_off[k] >= v_on[k]) begin
                back = longint'(v_lvl[k]) * atk_t / at_least_one(peak_lvl);
                v_on[k] = (back >= now) ? 32'd0 : now - back[31:0];
                v_active[k] = 1'b1;
            end
        end else if (v_present[k] && v_off[k] < v_on[k]) begin
            v_off[k] = now;
        end
    endtask

    initial begin
        for (int i = 0; i < SINE_DEPTH; i++) sine_lut[i] = sine_q14(i);
    end

    assign samples_owed = sample_q.size();

    // watch registers, requests and samples
    always @(posedge aclk) begin
        logic signed [19:0] want;
        if (!aresetn) begin
            atk_t <= ATTACK_RST;
            dec_t <= DECAY_RST;
            rel_t <= RELEASE_RST;
            peak_lvl <= PEAK_RST;
            sus_lvl <= SUSTAIN_RST;
            for (int k = 0; k < KEYS; k++) begin
                v_present[k] = 1'b0;
                v_active[k] = 1'b0;
                v_on[k] = 0;
                v_off[k] = 0;
                v_lvl[k] = 0;
            end
            sample_q.delete();
            mismatches <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ATTACK:  atk_t <= cfg_wdata;
                    REG_DECAY:   dec_t <= cfg_wdata;
                    REG_RELEASE: rel_t <= cfg_wdata;
                    REG_PEAK:    peak_lvl <= cfg_wdata[15:0];
                    REG_SUSTAIN: sus_lvl <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    $display("%0t: sample with none owed, expected none, actual %0d",
                             $time, m_sample_value);
                    mismatches <= mismatches + 1;
                end else begin
                    want = sample_q.pop_front();
                    if (want !== m_sample_value) begin
                        $display("%0t: sample_value expected %0d, actual %0d",
                                 $time, want, m_sample_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_op) begin
                    if (s_key_index < KEYS)
                        apply_key(s_key_index, s_key_pressed, s_time_stamp);
                end else begin
                    mix_sample(s_time_stamp, want);
                    sample_q.push_back(want);
                end
            end
        end
    end
endmodule

// ----- tb/polyphonic_adsr_voice_mixer_tb.sv -----
// stimulus, idling, register phases and verdict for the voice mixer
`timescale 1ns / 1ps
module polyphonic_adsr_voice_mixer_tb;
    import pavm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int OP_TICK = 0;
    localparam int OP_KEY = 1;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_op;
    logic [3:0] s_key_index;
    logic s_key_pressed;
    logic [31:0] s_time_stamp;
    logic m_valid;
    logic m_ready;
    logic signed [19:0] m_sample_value;
    int mismatches;
    int samples_owed;
    int cycles;
    int samples_seen;
    logic send_quiet;
    logic [31:0] now_ts;

    polyphonic_adsr_voice_mixer dut (.*);

    pavm_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back up the block
    initial begin
        int stall;
        m_ready = 1'b0;
        samples_seen = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (samples_seen == 40) begin
                m_ready <= 1'b0;
                repeat (4000) @(posedge aclk);
            end
            stall = ((samples_seen / 25) % 3 == 1) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            samples_seen++;
        end
    end

    // one request, after a random gap
    task automatic send_request(input int op, input int key, input logic down,
                                input logic [31:0] ts);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op[0];
        s_key_index <= key[3:0];
        s_key_pressed <= down;
        s_time_stamp <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drain and let a trailing key request finish before touching registers
    task automatic settle;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (samples_owed != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_envelope(input logic [31:0] a, input logic [31:0] d,
                                 input logic [31:0] r, input logic [15:0] pk,
                                 input logic [15:0] sus);
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_RELEASE, r);
        write_reg(REG_PEAK, {16'd0, pk});
        write_reg(REG_SUSTAIN, {16'd0, sus});
    endtask

    // random requests: mostly steady time with small steps, some jumps
    task automatic random_run(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) now_ts = $urandom;
            else if (pick < 6) now_ts = now_ts - $urandom_range(0, 3000);
            else now_ts = now_ts + $urandom_range(0, 5000);
            if ($urandom_range(0, 1))
                send_request(OP_TICK, $urandom_range(0, 15), 1'($urandom_range(0, 1)), now_ts);
            else
                send_request(OP_KEY, $urandom_range(0, 15), 1'($urandom_range(0, 1)), now_ts);
        end
    endtask

    initial begin
        cycles = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_key_index = '0;
        s_key_pressed = 1'b0;
        s_time_stamp = '0;
        send_quiet = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stamp edge cases, every envelope segment, re-arm, ignored keys
        send_request(OP_TICK, 0, 1'b0, 32'd0);
        send_request(OP_KEY, 0, 1'b1, 32'd0);
        send_request(OP_TICK, 0, 1'b0, 32'd0);
        send_request(OP_KEY, 15, 1'b1, 32'd100);
        send_request(OP_TICK, 0, 1'b0, 32'd3000);
        send_request(OP_TICK, 0, 1'b0, 32'd6900);
        send_request(OP_TICK, 0, 1'b0, 32'd20000);
        send_request(OP_KEY, 15, 1'b1, 32'd20500);
        send_request(OP_KEY, 15, 1'b0, 32'd21000);
        send_request(OP_KEY, 3, 1'b0, 32'd21000);
        send_request(OP_TICK, 0, 1'b0, 32'd25000);
        send_request(OP_KEY, 15, 1'b1, 32'd26000);
        send_request(OP_TICK, 0, 1'b0, 32'd27000);
        send_request(OP_KEY, 15, 1'b0, 32'd28000);
        send_request(OP_TICK, 0, 1'b0, 32'd60000);
        send_request(OP_KEY, 7, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_TICK, 0, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_TICK, 0, 1'b0, 32'd5);
        send_request(OP_KEY, 7, 1'b0, 32'hFFFF_FFF0);
        send_request(OP_KEY, 7, 1'b1, 32'hFFFF_FFF8);
        send_request(OP_TICK, 0, 1'b0, 32'h8000_0000);
        now_ts = 32'd70000;

        // default registers
        random_run(80);
        settle();
        load_envelope(32'd1, 32'd1, 32'd1, 16'd32768, 16'd0);
        send_quiet = 1'b1;
        random_run(70);
        settle();
        load_envelope(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd32768);
        send_quiet = 1'b0;
        random_run(70);
        settle();
        // decay that rises toward a sustain above peak
        load_envelope(32'd3000, 32'd2000, 32'd5000, 16'd20000, 16'd30000);
        random_run(80);
        settle();
        load_envelope($urandom_range(1, 20000), $urandom_range(1, 20000),
                      $urandom_range(1, 20000), 16'($urandom_range(1, 32768)),
                      16'($urandom_range(0, 32768)));
        random_run(80);
        settle();

        if (mismatches == 0 && samples_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
